@@ rtl/sha_auth_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 authentication digest package
// Payload structs, initial hash words, round constants and the SHA-256
// helper functions used by the round core; the types are also used by the top level.
// ----------------------------------------------------------------------------
package sha_auth_pkg;

    // Input request: three 16-byte values, byte 0 in the high bits
    typedef struct packed {
        logic [63:0] random_a_high;
        logic [63:0] random_a_low;
        logic [63:0] auth_high;
        logic [63:0] auth_low;
        logic [63:0] random_b_high;
        logic [63:0] random_b_low;
    } t_req;

    // Result: 32-byte digest, big-endian
    typedef struct packed {
        logic [63:0] digest_0;
        logic [63:0] digest_1;
        logic [63:0] digest_2;
        logic [63:0] digest_3;
    } t_rsp;

    typedef logic [31:0] t_word;

    // Control from the sequencer to the round core
    typedef struct packed {
        logic       load;   // load message words and initial hash
        logic       step;   // run one compression round
        logic [5:0] round;  // round index for this step
    } t_core_ctl;

    // Padding words for a 384-bit message
    localparam t_word PAD_WORD_12 = 32'h8000_0000;
    localparam t_word PAD_WORD_13 = 32'h0000_0000;
    localparam t_word PAD_WORD_14 = 32'h0000_0000;
    localparam t_word PAD_WORD_15 = 32'h0000_0180;

    localparam t_word INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constant table
    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

@@ rtl/sha256_auth_digest_48byte_top.sv @@
// Busy is high from the cycle after start through the o_done digest strobe.
// A new request is taken only in idle, so requests run one at a time through
// the single round unit (64 rounds).
// The digest is shown for one cycle with o_done; the receiver cannot stall.
// Reset (synchronous, active low) returns the sequencer to idle.
// ----------------------------------------------------------------------------
// SHA-256 authentication digest, top level
// Pads a 48-byte message to one block and runs one SHA-256 compression
// with a round-serial core under a small sequencer.
// ----------------------------------------------------------------------------
module sha256_auth_digest_48byte_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sha_auth_pkg::t_req  i_req,
    output logic                o_done,
    output sha_auth_pkg::t_rsp  o_rsp
);
    import sha_auth_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic [5:0] r_round;
    logic [5:0] n_round;
    t_core_ctl  core_ctl;
    t_rsp       digest;

    // Sequencer: load, 64 rounds, then output strobe
    always_comb begin
        n_state = r_state;
        n_round = r_round;
        core_ctl.load  = 1'b0;
        core_ctl.step  = 1'b0;
        core_ctl.round = r_round;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    core_ctl.load = 1'b1;
                    n_round = '0;
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                core_ctl.step = 1'b1;
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
        end
    end

    sha_auth_core u_core (
        .i_clk    (i_clk),
        .i_ctl    (core_ctl),
        .i_req    (i_req),
        .o_digest (digest)
    );

    assign busy   = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_DONE);
    assign o_rsp  = digest;

endmodule

@@ rtl/sha_auth_core.sv @@
// ----------------------------------------------------------------------------
// SHA-256 round core
// One shared round unit: a 16-word message schedule window and the eight
// working variables, advanced by one round per step.
// ----------------------------------------------------------------------------
module sha_auth_core (
    input  logic                     i_clk,
    input  sha_auth_pkg::t_core_ctl  i_ctl,
    input  sha_auth_pkg::t_req       i_req,
    output sha_auth_pkg::t_rsp       o_digest
);
    import sha_auth_pkg::*;

    t_word r_w [16];
    t_word n_w [16];
    t_word r_v [8];
    t_word n_v [8];

    t_word w_new;
    t_word t1;
    t_word t2;
    t_word ch;
    t_word maj;
    t_word h_sum [8];

    // Schedule word for the next window slot and the round arithmetic
    always_comb begin
        w_new = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1    = r_v[7] + big_sigma1(r_v[4]) + ch + round_k(i_ctl.round) + r_w[0];
        t2    = big_sigma0(r_v[0]) + maj;
    end

    // Next state of the window and working variables
    always_comb begin
        n_w = r_w;
        n_v = r_v;
        priority if (i_ctl.load) begin
            n_w[0]  = i_req.random_a_high[63:32];
            n_w[1]  = i_req.random_a_high[31:0];
            n_w[2]  = i_req.random_a_low[63:32];
            n_w[3]  = i_req.random_a_low[31:0];
            n_w[4]  = i_req.auth_high[63:32];
            n_w[5]  = i_req.auth_high[31:0];
            n_w[6]  = i_req.auth_low[63:32];
            n_w[7]  = i_req.auth_low[31:0];
            n_w[8]  = i_req.random_b_high[63:32];
            n_w[9]  = i_req.random_b_high[31:0];
            n_w[10] = i_req.random_b_low[63:32];
            n_w[11] = i_req.random_b_low[31:0];
            n_w[12] = PAD_WORD_12;
            n_w[13] = PAD_WORD_13;
            n_w[14] = PAD_WORD_14;
            n_w[15] = PAD_WORD_15;
            for (int i = 0; i < 8; i++) begin
                n_v[i] = INIT_H[i];
            end
        end else if (i_ctl.step) begin
            for (int i = 0; i < 15; i++) begin
                n_w[i] = r_w[i+1];
            end
            n_w[15] = w_new;
            n_v[7] = r_v[6];
            n_v[6] = r_v[5];
            n_v[5] = r_v[4];
            n_v[4] = r_v[3] + t1;
            n_v[3] = r_v[2];
            n_v[2] = r_v[1];
            n_v[1] = r_v[0];
            n_v[0] = t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        r_v <= n_v;
    end

    // Final feed-forward of the initial hash
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            h_sum[i] = r_v[i] + INIT_H[i];
        end
        o_digest.digest_0 = {h_sum[0], h_sum[1]};
        o_digest.digest_1 = {h_sum[2], h_sum[3]};
        o_digest.digest_2 = {h_sum[4], h_sum[5]};
        o_digest.digest_3 = {h_sum[6], h_sum[7]};
    end

endmodule
